// ===== sv/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg - shared types and constants for the drive wheel command block
// Mode codes, wheel pin codes, register indexes, the command control word
// passed from the front end to the back end, and the back-end state type.
// ----------------------------------------------------------------------------
package dwc_pkg;

  // Duty output width and pin code width
  localparam int DUTY_W = 15;
  localparam int PIN_W  = 2;
  localparam int GAIN_W = 32;
  localparam int NUM_WHEELS = 4;

  // Drive modes as stored in the mode register
  typedef enum logic [1:0] {
    MODE_FRONT_BACK = 2'd0,
    MODE_LEFT_RIGHT = 2'd1,
    MODE_ROTATE     = 2'd2
  } mode_t;

  // H-bridge pin codes
  typedef enum logic [PIN_W-1:0] {
    PIN_OFF = 2'd0,
    PIN_IN2 = 2'd1,
    PIN_IN1 = 2'd2
  } pin_code_t;

  // Configuration register indexes
  localparam logic [1:0] REG_GAIN_FL = 2'd0;
  localparam logic [1:0] REG_GAIN_FR = 2'd1;
  localparam logic [1:0] REG_GAIN_RL = 2'd2;
  localparam logic [1:0] REG_GAIN_RR = 2'd3;

  // Classified command control bits: pin2_* is set when a nonzero speed on
  // that side should drive the in1-high code
  typedef struct packed {
    logic  reorient;
    mode_t mode;
    logic  use_z;
    logic  pin2_left;
    logic  pin2_right;
  } cmd_ctrl_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQ_X,
    BK_SQ_Y,
    BK_SUM,
    BK_ROOT,
    BK_MUL,
    BK_SAT,
    BK_EMIT
  } back_state_t;

endpackage

// ===== sv/dwc_front.sv =====
// ----------------------------------------------------------------------------
// dwc_front - command classifier
// Accepts velocity beats, updates the drive mode, works out magnitudes and
// wheel direction flags, and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
module dwc_front
  import dwc_pkg::*;
#(
  parameter int VELOCITY_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VELOCITY_WIDTH-1:0] in_x_velocity,
  input  logic signed [VELOCITY_WIDTH-1:0] in_y_velocity,
  input  logic signed [VELOCITY_WIDTH-1:0] in_z_velocity,
  input  logic                             q_full,
  output logic                             q_push,
  output cmd_ctrl_t                        q_ctrl,
  output logic        [VELOCITY_WIDTH-1:0] q_mag_x,
  output logic        [VELOCITY_WIDTH-1:0] q_mag_y,
  output logic        [VELOCITY_WIDTH-1:0] q_mag_z
);

  mode_t mode_r;
  mode_t mode_nxt;
  logic  reorient;
  logic  x_nz, y_nz, z_nz;
  logic  x_neg, y_neg, z_neg;
  logic  neg_all;
  logic  lr;
  logic  neg_left, neg_right;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Classify the beat
  always_comb begin
    x_nz  = (in_x_velocity != '0);
    y_nz  = (in_y_velocity != '0);
    z_nz  = (in_z_velocity != '0);
    x_neg = in_x_velocity[VELOCITY_WIDTH-1];
    y_neg = in_y_velocity[VELOCITY_WIDTH-1];
    z_neg = in_z_velocity[VELOCITY_WIDTH-1];

    mode_nxt = mode_r;
    reorient = 1'b0;
    if ((x_nz && mode_r != MODE_LEFT_RIGHT) || (y_nz && mode_r != MODE_FRONT_BACK)) begin
      mode_nxt = x_nz ? MODE_LEFT_RIGHT : MODE_FRONT_BACK;
      reorient = 1'b1;
    end else if (z_nz && mode_r != MODE_ROTATE) begin
      mode_nxt = MODE_ROTATE;
      reorient = 1'b1;
    end

    // Wheel signs: left wheels follow z, right wheels follow -z
    neg_all   = x_neg || y_neg;
    lr        = (mode_nxt == MODE_LEFT_RIGHT);
    neg_left  = (z_nz && z_neg) ^ neg_all ^ lr;
    neg_right = (z_nz && !z_neg) ^ neg_all;

    q_ctrl.reorient   = reorient;
    q_ctrl.mode       = mode_nxt;
    q_ctrl.use_z      = z_nz;
    q_ctrl.pin2_left  = neg_left;
    q_ctrl.pin2_right = !neg_right;

    // Magnitudes; the most negative value maps to its unsigned magnitude
    q_mag_x = x_neg ? (VELOCITY_WIDTH'(~in_x_velocity) + VELOCITY_WIDTH'(1))
                    : VELOCITY_WIDTH'(in_x_velocity);
    q_mag_y = y_neg ? (VELOCITY_WIDTH'(~in_y_velocity) + VELOCITY_WIDTH'(1))
                    : VELOCITY_WIDTH'(in_y_velocity);
    q_mag_z = z_neg ? (VELOCITY_WIDTH'(~in_z_velocity) + VELOCITY_WIDTH'(1))
                    : VELOCITY_WIDTH'(in_z_velocity);
  end

  // Hold the mode between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FRONT_BACK;
    end else if (q_push) begin
      mode_r <= mode_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_mode_kept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_ctrl.reorient |=> $stable(mode_r))
    else $error("mode changed without reorient");
`endif

endmodule

// ===== sv/dwc_queue.sv =====
// ----------------------------------------------------------------------------
// dwc_queue - two-entry command queue
// Decouples the classifier from the wheel sequencer.
// ----------------------------------------------------------------------------
module dwc_queue
  import dwc_pkg::*;
#(
  parameter int DATA_W = 56
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              empty
);

  logic [DATA_W-1:0] entry_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/dwc_back.sv =====
// ----------------------------------------------------------------------------
// dwc_back - wheel speed sequencer
// Squares and sums the planar magnitudes, takes an integer square root one
// bit a cycle (both skipped for rotate commands), scales each wheel by its
// gain on a shared multiplier, saturates, and loads the result register.
// ----------------------------------------------------------------------------
module dwc_back
  import dwc_pkg::*;
#(
  parameter int VELOCITY_WIDTH = 16,
  parameter int DUTY_LIMIT     = 16800
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  cmd_ctrl_t                 q_ctrl,
  input  logic [VELOCITY_WIDTH-1:0] q_mag_x,
  input  logic [VELOCITY_WIDTH-1:0] q_mag_y,
  input  logic [VELOCITY_WIDTH-1:0] q_mag_z,
  input  logic [GAIN_W-1:0]         gain [NUM_WHEELS],
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_reorient,
  output logic [1:0]                out_drive_mode,
  output logic [DUTY_W-1:0]         out_duty [NUM_WHEELS],
  output logic [PIN_W-1:0]          out_pins [NUM_WHEELS]
);

  localparam int VW    = VELOCITY_WIDTH;
  localparam int PROD_W = VW + GAIN_W;
  localparam int SCL_W  = PROD_W - 16;
  localparam int RAD_W  = 2 * VW;
  localparam int REM_W  = VW + 2;
  localparam int CNT_W  = $clog2(VW);
  localparam logic [SCL_W-1:0] LIMIT = SCL_W'(DUTY_LIMIT);

  back_state_t state_r, state_nxt;

  cmd_ctrl_t         ctrl_r;
  logic [VW-1:0]     mag_x_r, mag_y_r, mag_r;
  logic [PROD_W-1:0] prod_r;
  logic [RAD_W-1:0]  acc_r, rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [VW-1:0]     root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        wheel_r;
  logic [DUTY_W-1:0] duty_stg_r [NUM_WHEELS];
  pin_code_t         pins_stg_r [NUM_WHEELS];
  logic              out_valid_r;

  logic [VW-1:0]     mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic              load_out;
  logic [REM_W+1:0]  rem_sh, trial;
  logic              root_ge;
  logic [SCL_W-1:0]  scaled, sat;
  logic              pin2;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_ctrl.use_z ? BK_MUL : BK_SQ_X;
        end
      end
      BK_SQ_X: state_nxt = BK_SQ_Y;
      BK_SQ_Y: state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_ROOT;
      BK_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:  state_nxt = BK_SAT;
      BK_SAT:  state_nxt = (wheel_r == 2'd3) ? BK_EMIT : BK_MUL;
      BK_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs and multiplier operand select
  always_comb begin
    q_pop    = (state_r == BK_IDLE) && !q_empty;
    load_out = (state_r == BK_EMIT) && (!out_valid_r || out_ready);
    mul_a    = mag_r;
    mul_b    = gain[wheel_r];
    unique case (state_r)
      BK_SQ_X: begin
        mul_a = mag_x_r;
        mul_b = GAIN_W'(mag_x_r);
      end
      BK_SQ_Y: begin
        mul_a = mag_y_r;
        mul_b = GAIN_W'(mag_y_r);
      end
      default: begin
        mul_a = mag_r;
        mul_b = gain[wheel_r];
      end
    endcase
  end

  // Shared multiplier, root step and saturation
  always_comb begin
    prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    root_ge = (rem_sh >= trial);
    scaled  = prod_r[PROD_W-1:16];
    sat     = (scaled > LIMIT) ? LIMIT : scaled;
    pin2    = wheel_r[0] ? ctrl_r.pin2_right : ctrl_r.pin2_left;
  end

  // Sequencer state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        ctrl_r  <= q_ctrl;
        mag_x_r <= q_mag_x;
        mag_y_r <= q_mag_y;
        mag_r   <= q_mag_z;
        wheel_r <= 2'd0;
      end
      BK_SQ_X: prod_r <= prod;
      BK_SQ_Y: begin
        acc_r  <= prod_r[RAD_W-1:0];
        prod_r <= prod;
      end
      BK_SUM: begin
        rad_r  <= acc_r + prod_r[RAD_W-1:0];
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(VW - 1);
      end
      BK_ROOT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= root_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[VW-2:0], root_ge};
        cnt_r  <= cnt_r - CNT_W'(1);
        mag_r  <= {root_r[VW-2:0], root_ge};
      end
      BK_MUL: prod_r <= prod;
      BK_SAT: begin
        duty_stg_r[wheel_r] <= sat[DUTY_W-1:0];
        if (sat == '0) begin
          pins_stg_r[wheel_r] <= PIN_OFF;
        end else begin
          pins_stg_r[wheel_r] <= pin2 ? PIN_IN1 : PIN_IN2;
        end
        wheel_r <= wheel_r + 2'd1;
      end
      BK_EMIT: begin
        if (load_out) begin
          out_reorient   <= ctrl_r.reorient;
          out_drive_mode <= ctrl_r.mode;
          for (int i = 0; i < NUM_WHEELS; i++) begin
            out_duty[i] <= duty_stg_r[i];
            out_pins[i] <= pins_stg_r[i];
          end
        end
      end
      default: begin
        wheel_r <= wheel_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_sat_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SAT && wheel_r == 2'd3 |=> state_r == BK_EMIT)
    else $error("wheel sequence did not end in emit");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && state_r == BK_IDLE)
    else $error("result load lost");
  a_pins_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pins[0] != 2'd3 && out_pins[1] != 2'd3 &&
                    out_pins[2] != 2'd3 && out_pins[3] != 2'd3)
    else $error("illegal pin code");
`endif

endmodule

// ===== sv/drive_wheel_command.sv =====
// ----------------------------------------------------------------------------
// drive_wheel_command - body velocity to wheel duty and direction
// Tracks the drive mode, turns each velocity command into four wheel speeds,
// scales them by per-wheel gains and gives duty magnitudes and pin codes.
//
//   channel  handshake            payload
//   in_      in_valid/in_ready    x, y, z velocity
//   out_     out_valid/out_ready  reorient, mode, 4 duty, 4 pin codes
//   cfg_     cfg_we               cfg_index, cfg_data (wheel gains)
//
// In the back end a planar command runs two squarings on the shared
// multiplier, a sum, one root bit a cycle, then a gain multiply and a
// saturation step per wheel. A rotate command skips the squarings and the
// root. The two-entry queue lets the front accept beats while the back end
// or a stalled output is busy. Reset is synchronous and active low; it sets
// front-back mode and zero gains.
// ----------------------------------------------------------------------------
module drive_wheel_command
  import dwc_pkg::*;
#(
  parameter int VELOCITY_WIDTH = 16,
  parameter int DUTY_LIMIT     = 16800
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VELOCITY_WIDTH-1:0] in_x_velocity,
  input  logic signed [VELOCITY_WIDTH-1:0] in_y_velocity,
  input  logic signed [VELOCITY_WIDTH-1:0] in_z_velocity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_reorient,
  output logic        [1:0]                out_drive_mode,
  output logic        [DUTY_W-1:0]         out_duty_front_left,
  output logic        [DUTY_W-1:0]         out_duty_front_right,
  output logic        [DUTY_W-1:0]         out_duty_rear_left,
  output logic        [DUTY_W-1:0]         out_duty_rear_right,
  output logic        [PIN_W-1:0]          out_pins_front_left,
  output logic        [PIN_W-1:0]          out_pins_front_right,
  output logic        [PIN_W-1:0]          out_pins_rear_left,
  output logic        [PIN_W-1:0]          out_pins_rear_right,
  input  logic                             cfg_we,
  input  logic        [1:0]                cfg_index,
  input  logic        [GAIN_W-1:0]         cfg_data
);

  localparam int VW     = VELOCITY_WIDTH;
  localparam int CTRL_W = $bits(cmd_ctrl_t);
  localparam int Q_W    = CTRL_W + 3 * VW;

  logic [GAIN_W-1:0] gain_r [NUM_WHEELS];

  logic       q_push, q_pop, q_full, q_empty;
  cmd_ctrl_t  f_ctrl, b_ctrl;
  logic [VW-1:0] f_mag_x, f_mag_y, f_mag_z;
  logic [VW-1:0] b_mag_x, b_mag_y, b_mag_z;
  logic [Q_W-1:0] q_wdata, q_rdata;
  logic [DUTY_W-1:0] duty [NUM_WHEELS];
  logic [PIN_W-1:0]  pins [NUM_WHEELS];

  // Gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        gain_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_FL: gain_r[0] <= cfg_data;
        REG_GAIN_FR: gain_r[1] <= cfg_data;
        REG_GAIN_RL: gain_r[2] <= cfg_data;
        REG_GAIN_RR: gain_r[3] <= cfg_data;
        default:     gain_r[0] <= gain_r[0];
      endcase
    end
  end

  dwc_front #(
    .VELOCITY_WIDTH (VW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_velocity (in_x_velocity),
    .in_y_velocity (in_y_velocity),
    .in_z_velocity (in_z_velocity),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ctrl        (f_ctrl),
    .q_mag_x       (f_mag_x),
    .q_mag_y       (f_mag_y),
    .q_mag_z       (f_mag_z)
  );

  // Pack and unpack queue entries
  assign q_wdata = {f_ctrl, f_mag_x, f_mag_y, f_mag_z};
  assign {b_ctrl, b_mag_x, b_mag_y, b_mag_z} = q_rdata;

  dwc_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  dwc_back #(
    .VELOCITY_WIDTH (VW),
    .DUTY_LIMIT     (DUTY_LIMIT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_ctrl         (b_ctrl),
    .q_mag_x        (b_mag_x),
    .q_mag_y        (b_mag_y),
    .q_mag_z        (b_mag_z),
    .gain           (gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reorient   (out_reorient),
    .out_drive_mode (out_drive_mode),
    .out_duty       (duty),
    .out_pins       (pins)
  );

  assign out_duty_front_left  = duty[0];
  assign out_duty_front_right = duty[1];
  assign out_duty_rear_left   = duty[2];
  assign out_duty_rear_right  = duty[3];
  assign out_pins_front_left  = pins[0];
  assign out_pins_front_right = pins[1];
  assign out_pins_rear_left   = pins[2];
  assign out_pins_rear_right  = pins[3];

endmodule
